[hw/rtl/arp_pkg.sv]
`default_nettype none
package arp_pkg;
    localparam int TABLE_ENTRIES_DEF   = 16;
    localparam int PENDING_ENTRIES_DEF = 8;
    localparam int QUEUE_ENTRIES_DEF   = 16;

    localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [15:0] ARP_OP_REQ = 16'd1;
    localparam logic [15:0] ARP_OP_REP = 16'd2;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_RECV = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [2:0] OUT_IPV4    = 3'd0;
    localparam logic [2:0] OUT_ARP_REQ = 3'd1;
    localparam logic [2:0] OUT_ARP_REP = 3'd2;
    localparam logic [2:0] OUT_DELIVER = 3'd3;
    localparam logic [2:0] OUT_DROP    = 3'd4;

    localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
    localparam logic [1:0] CFG_OWN_IP   = 2'd1;
    localparam logic [1:0] CFG_LIFETIME = 2'd2;
    localparam logic [1:0] CFG_RETRY    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_TBL_SCAN,
        ST_TICK_TBL,
        ST_TICK_PND,
        ST_LEARN,
        ST_Q_SCAN,
        ST_PND_CLR,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic scan_clr;   // reset scan index/accumulators
        logic scan_inc;   // advance scan index
        logic tbl_scan;   // evaluate table entry at index (find/free/min)
        logic tick_tbl;   // age table entry at index
        logic tick_pnd;   // age pending entry at index (may queue a result)
        logic q_step;     // process queue entry at index
        logic send_do;    // apply send decision
        logic recv_do;    // apply receive decision (front results)
        logic learn_do;   // write table
        logic pnd_clr;    // clear pending for sender ip
        logic emit_pop;   // result taken
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] kind;
        logic       tbl_done;
        logic       pnd_done;
        logic       q_done;
        logic       res_valid; // a result is held
        logic       learn_req; // receive path needs learn + flush
    } sts_t;
endpackage
`default_nettype wire

[hw/rtl/arp_ctrl.sv]
`default_nettype none
module arp_ctrl
    import arp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_fire,
    input  wire logic out_fire,
    input  sts_t      sts,
    output cmd_t      cmd,
    output state_t    state,
    output logic      busy
);
    state_t state_reg, state_next, ret_reg, ret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign state = state_reg;
    assign busy  = (state_reg != ST_IDLE);

    // next state; any pending result is drained in ST_EMIT before continuing
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_TBL_SCAN;
            ST_TBL_SCAN: begin
                if (sts.tbl_done)
                    state_next = (sts.kind == KIND_TICK) ? ST_TICK_TBL : ST_DECIDE;
            end
            ST_DECIDE: begin
                if (sts.learn_req) ret_next = ST_LEARN;
                else               ret_next = ST_IDLE;
                state_next = ST_EMIT;
            end
            ST_TICK_TBL: if (sts.tbl_done) state_next = ST_TICK_PND;
            ST_TICK_PND: begin
                if (sts.res_valid) begin
                    ret_next   = ST_TICK_PND;
                    state_next = ST_EMIT;
                end else if (sts.pnd_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LEARN: state_next = ST_Q_SCAN;
            ST_Q_SCAN: begin
                if (sts.res_valid) begin
                    ret_next   = ST_Q_SCAN;
                    state_next = ST_EMIT;
                end else if (sts.q_done) begin
                    state_next = ST_PND_CLR;
                end
            end
            ST_PND_CLR: state_next = ST_IDLE;
            ST_EMIT: begin
                if (!sts.res_valid) state_next = ret_reg;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load     = in_fire;
                cmd.scan_clr = 1'b1;
            end
            ST_TBL_SCAN: begin
                cmd.tbl_scan = 1'b1;
                cmd.scan_inc = !sts.tbl_done;
                cmd.scan_clr = sts.tbl_done;
            end
            ST_DECIDE: begin
                cmd.send_do = (sts.kind == KIND_SEND);
                cmd.recv_do = (sts.kind == KIND_RECV);
            end
            ST_TICK_TBL: begin
                cmd.tick_tbl = 1'b1;
                cmd.scan_inc = !sts.tbl_done;
                cmd.scan_clr = sts.tbl_done;
            end
            ST_TICK_PND: begin
                if (!sts.res_valid) begin
                    cmd.tick_pnd = 1'b1;
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_LEARN: begin
                cmd.learn_do = 1'b1;
                cmd.scan_clr = 1'b1;
            end
            ST_Q_SCAN: begin
                if (!sts.res_valid) begin
                    cmd.q_step   = 1'b1;
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_PND_CLR: cmd.pnd_clr = 1'b1;
            ST_EMIT: cmd.emit_pop = out_fire;
            default: cmd = '0;
        endcase
    end

    property p_load_idle;
        @(posedge aclk) disable iff (!aresetn) cmd.load |-> state_reg == ST_IDLE;
    endproperty
    a_load_idle: assert property (p_load_idle) else $error("load outside idle");

    property p_pop_emit;
        @(posedge aclk) disable iff (!aresetn) cmd.emit_pop |-> state_reg == ST_EMIT;
    endproperty
    a_pop_emit: assert property (p_pop_emit) else $error("result pop outside emit");

    property p_start;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_IDLE && in_fire) |=> state_reg == ST_TBL_SCAN;
    endproperty
    a_start: assert property (p_start) else $error("accept did not start scan");
endmodule
`default_nettype wire

[hw/rtl/arp_dp.sv]
`default_nettype none
module arp_dp
    import arp_pkg::*;
#(
    parameter int TABLE_ENTRIES   = TABLE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = PENDING_ENTRIES_DEF,
    parameter int QUEUE_ENTRIES   = QUEUE_ENTRIES_DEF
)(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [47:0] cfg_data,
    input  wire logic [1:0]  in_kind,
    input  wire logic [31:0] in_next_hop_ip,
    input  wire logic [15:0] in_datagram_id,
    input  wire logic [47:0] in_frame_dst_mac,
    input  wire logic [15:0] in_ether_type,
    input  wire logic        in_payload_ok,
    input  wire logic [15:0] in_arp_opcode,
    input  wire logic [31:0] in_sender_ip,
    input  wire logic [47:0] in_sender_mac,
    input  wire logic [31:0] in_target_ip,
    input  wire logic [47:0] in_target_mac,
    input  wire logic [15:0] in_elapsed_ms,
    input  wire logic        tick_more,   // pending scan still has entries
    output logic [2:0]       res_kind,
    output logic [47:0]      res_mac,
    output logic [31:0]      res_ip,
    output logic [15:0]      res_id,
    output logic             res_last
);
    localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int QW = (QUEUE_ENTRIES > 1) ? $clog2(QUEUE_ENTRIES) : 1;
    localparam int MX = (TABLE_ENTRIES > QUEUE_ENTRIES) ?
        ((TABLE_ENTRIES > PENDING_ENTRIES) ? TABLE_ENTRIES : PENDING_ENTRIES) :
        ((QUEUE_ENTRIES > PENDING_ENTRIES) ? QUEUE_ENTRIES : PENDING_ENTRIES);
    localparam int SW = $clog2(MX + 1);
    localparam int CW = $clog2(QUEUE_ENTRIES + 1);

    // configuration
    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic [15:0] life_reg, retry_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
            life_reg    <= 16'd30000;
            retry_reg   <= 16'd5000;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_OWN_MAC:  own_mac_reg <= cfg_data;
                CFG_OWN_IP:   own_ip_reg  <= cfg_data[31:0];
                CFG_LIFETIME: life_reg    <= cfg_data[15:0];
                CFG_RETRY:    retry_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic [1:0]  kind_reg;
    logic [31:0] nh_reg, sip_reg, tip_reg;
    logic [15:0] id_reg, et_reg, op_reg, el_reg;
    logic [47:0] fdst_reg, smac_reg, tmac_reg;
    logic        pok_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;         nh_reg  <= in_next_hop_ip;
            id_reg   <= in_datagram_id;  fdst_reg <= in_frame_dst_mac;
            et_reg   <= in_ether_type;   pok_reg <= in_payload_ok;
            op_reg   <= in_arp_opcode;   sip_reg <= in_sender_ip;
            smac_reg <= in_sender_mac;   tip_reg <= in_target_ip;
            tmac_reg <= in_target_mac;   el_reg  <= in_elapsed_ms;
        end
    end

    // storage
    logic [TABLE_ENTRIES-1:0]   tv_reg;
    logic [31:0] tip_mem [TABLE_ENTRIES];
    logic [47:0] tmac_mem [TABLE_ENTRIES];
    logic [15:0] tttl_mem [TABLE_ENTRIES];
    logic [PENDING_ENTRIES-1:0] pv_reg;
    logic [31:0] pip_mem [PENDING_ENTRIES];
    logic [15:0] pttl_mem [PENDING_ENTRIES];
    logic [31:0] qip_mem [QUEUE_ENTRIES];
    logic [15:0] qh_mem [QUEUE_ENTRIES];
    logic [CW-1:0] qcnt_reg;

    // scan index and accumulators
    logic [SW-1:0] idx_reg;
    logic [CW-1:0] wr_reg;      // compaction write pointer
    logic          thit_reg, tfree_reg;
    logic [TW-1:0] thit_idx_reg, tfree_idx_reg, tmin_idx_reg;
    logic [15:0]   tmin_reg;

    logic [TW-1:0] ti;
    logic [PW-1:0] pi;
    logic [QW-1:0] qi;
    assign ti = idx_reg[TW-1:0];
    assign pi = idx_reg[PW-1:0];
    assign qi = idx_reg[QW-1:0];

    logic tbl_done, pnd_done, q_done;
    assign tbl_done = (idx_reg == SW'(TABLE_ENTRIES - 1));
    assign pnd_done = (idx_reg >= SW'(PENDING_ENTRIES));
    assign q_done   = (idx_reg >= SW'(qcnt_reg));

    // pending lookup (one comparator per pending entry, parallel)
    logic          pfind, pfree;
    logic [PW-1:0] pfind_idx, pfree_idx;
    logic [31:0]   lookup_ip;
    assign lookup_ip = (kind_reg == KIND_SEND) ? nh_reg : sip_reg;
    always_comb begin
        pfind = 1'b0; pfree = 1'b0; pfind_idx = '0; pfree_idx = '0;
        for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
            if (pv_reg[i] && pip_mem[i] == lookup_ip) begin
                pfind = 1'b1; pfind_idx = PW'(i);
            end
            if (!pv_reg[i]) begin
                pfree = 1'b1; pfree_idx = PW'(i);
            end
        end
    end

    // receive classification
    logic rx_ok, is_req, is_rep;
    assign rx_ok  = (fdst_reg == own_mac_reg || fdst_reg == MAC_BCAST) && pok_reg;
    assign is_req = op_reg == ARP_OP_REQ && tip_reg == own_ip_reg;
    assign is_rep = op_reg == ARP_OP_REP && tmac_reg == own_mac_reg;
    logic learn_req;
    assign learn_req = (kind_reg == KIND_RECV) && rx_ok && et_reg == ETH_ARP &&
                       (is_req || is_rep);

    // single result holding register
    logic        rv_reg;
    logic [2:0]  rk_reg;
    logic [47:0] rm_reg;
    logic [31:0] ri_reg;
    logic [15:0] rd_reg;
    logic        rl_reg;

    // last-result bookkeeping for scans: queue tail matches, tick tail requests
    logic q_any_after, p_any_after;
    always_comb begin
        q_any_after = 1'b0;
        for (int i = 0; i < QUEUE_ENTRIES; i++)
            if (SW'(i) > idx_reg && CW'(i) < qcnt_reg && qip_mem[i] == sip_reg)
                q_any_after = 1'b1;
        p_any_after = 1'b0;
        for (int i = 0; i < PENDING_ENTRIES; i++)
            if (SW'(i) > idx_reg && pv_reg[i] && pttl_mem[i] <= el_reg)
                p_any_after = 1'b1;
    end

    // any queued match at all (for the reply's last flag)
    logic q_any_after_all;
    always_comb begin
        q_any_after_all = 1'b0;
        for (int i = 0; i < QUEUE_ENTRIES; i++)
            if (CW'(i) < qcnt_reg && qip_mem[i] == sip_reg) q_any_after_all = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg   <= '0;
            pv_reg   <= '0;
            qcnt_reg <= '0;
            rv_reg   <= 1'b0;
            idx_reg  <= '0;
        end else begin
            if (cmd.emit_pop) rv_reg <= 1'b0;
            if (cmd.scan_clr) begin
                idx_reg <= '0;
                wr_reg  <= '0;
            end else if (cmd.scan_inc) begin
                idx_reg <= idx_reg + SW'(1);
            end
            if (cmd.load) begin
                thit_reg <= 1'b0; tfree_reg <= 1'b0; tmin_idx_reg <= '0;
                tmin_reg <= 16'hFFFF;
            end
            if (cmd.tbl_scan) begin
                if (tv_reg[ti] && tip_mem[ti] == lookup_ip && !thit_reg) begin
                    thit_reg <= 1'b1; thit_idx_reg <= ti;
                end
                if (!tv_reg[ti] && !tfree_reg) begin
                    tfree_reg <= 1'b1; tfree_idx_reg <= ti;
                end
                if (idx_reg == '0 || tttl_mem[ti] < tmin_reg) begin
                    tmin_reg <= tttl_mem[ti]; tmin_idx_reg <= ti;
                end
            end
            if (cmd.tick_tbl && tv_reg[ti]) begin
                if (tttl_mem[ti] <= el_reg) tv_reg[ti] <= 1'b0;
                else tttl_mem[ti] <= tttl_mem[ti] - el_reg;
            end
            if (cmd.tick_pnd && !pnd_done && pv_reg[pi]) begin
                if (pttl_mem[pi] <= el_reg) begin
                    pttl_mem[pi] <= retry_reg;
                    rv_reg <= 1'b1; rk_reg <= OUT_ARP_REQ;
                    rm_reg <= MAC_BCAST; ri_reg <= pip_mem[pi];
                    rd_reg <= '0; rl_reg <= !p_any_after;
                end else begin
                    pttl_mem[pi] <= pttl_mem[pi] - el_reg;
                end
            end
            // the holding register is already empty when a decision is applied
            if (cmd.send_do) begin
                if (thit_reg) begin
                    rv_reg <= 1'b1; rk_reg <= OUT_IPV4; rm_reg <= tmac_mem[thit_idx_reg];
                    ri_reg <= nh_reg; rd_reg <= id_reg; rl_reg <= 1'b1;
                end else if (qcnt_reg >= CW'(QUEUE_ENTRIES) || (!pfind && !pfree)) begin
                    rv_reg <= 1'b1; rk_reg <= OUT_DROP; rm_reg <= '0;
                    ri_reg <= nh_reg; rd_reg <= id_reg; rl_reg <= 1'b1;
                end else begin
                    if (!pfind) begin
                        pv_reg[pfree_idx]   <= 1'b1;
                        pip_mem[pfree_idx]  <= nh_reg;
                        pttl_mem[pfree_idx] <= retry_reg;
                        rv_reg <= 1'b1; rk_reg <= OUT_ARP_REQ; rm_reg <= MAC_BCAST;
                        ri_reg <= nh_reg; rd_reg <= '0; rl_reg <= 1'b1;
                    end
                    qip_mem[qcnt_reg[QW-1:0]] <= nh_reg;
                    qh_mem[qcnt_reg[QW-1:0]]  <= id_reg;
                    qcnt_reg <= qcnt_reg + CW'(1);
                end
            end
            if (cmd.recv_do) begin
                if (rx_ok && et_reg == ETH_IPV4) begin
                    rv_reg <= 1'b1; rk_reg <= OUT_DELIVER; rm_reg <= '0;
                    ri_reg <= '0; rd_reg <= id_reg; rl_reg <= 1'b1;
                end else if (rx_ok && et_reg == ETH_ARP && is_req) begin
                    rv_reg <= 1'b1; rk_reg <= OUT_ARP_REP; rm_reg <= smac_reg;
                    ri_reg <= sip_reg; rd_reg <= '0;
                    rl_reg <= !q_any_after_all;
                end
            end
            if (cmd.learn_do) begin
                if (thit_reg) begin
                    tip_mem[thit_idx_reg] <= sip_reg; tmac_mem[thit_idx_reg] <= smac_reg;
                    tttl_mem[thit_idx_reg] <= life_reg;
                end else if (tfree_reg) begin
                    tv_reg[tfree_idx_reg] <= 1'b1;
                    tip_mem[tfree_idx_reg] <= sip_reg; tmac_mem[tfree_idx_reg] <= smac_reg;
                    tttl_mem[tfree_idx_reg] <= life_reg;
                end else begin
                    tip_mem[tmin_idx_reg] <= sip_reg; tmac_mem[tmin_idx_reg] <= smac_reg;
                    tttl_mem[tmin_idx_reg] <= life_reg;
                end
            end
            if (cmd.q_step) begin
                if (q_done) begin
                    qcnt_reg <= wr_reg;
                end else if (qip_mem[qi] == sip_reg) begin
                    rv_reg <= 1'b1; rk_reg <= OUT_IPV4; rm_reg <= smac_reg;
                    ri_reg <= sip_reg; rd_reg <= qh_mem[qi]; rl_reg <= !q_any_after;
                end else begin
                    qip_mem[wr_reg[QW-1:0]] <= qip_mem[qi];
                    qh_mem[wr_reg[QW-1:0]]  <= qh_mem[qi];
                    wr_reg <= wr_reg + CW'(1);
                end
            end
            if (cmd.pnd_clr && pfind) pv_reg[pfind_idx] <= 1'b0;
        end
    end

    assign sts.kind      = kind_reg;
    assign sts.tbl_done  = tbl_done;
    assign sts.pnd_done  = pnd_done && !tick_more;
    assign sts.q_done    = q_done && qcnt_reg == wr_reg;
    assign sts.res_valid = rv_reg;
    assign sts.learn_req = learn_req;

    assign res_kind = rk_reg;
    assign res_mac  = rm_reg;
    assign res_ip   = ri_reg;
    assign res_id   = rd_reg;
    assign res_last = rl_reg;

    property p_qcnt;
        @(posedge aclk) disable iff (!aresetn) qcnt_reg <= CW'(QUEUE_ENTRIES);
    endproperty
    a_qcnt: assert property (p_qcnt) else $error("queue count overflow");

    property p_wr;
        @(posedge aclk) disable iff (!aresetn) cmd.q_step |-> wr_reg <= qcnt_reg;
    endproperty
    a_wr: assert property (p_wr) else $error("compaction pointer ahead of read");

    property p_nores_scan;
        @(posedge aclk) disable iff (!aresetn) (cmd.q_step || cmd.tick_pnd) |-> !rv_reg;
    endproperty
    a_nores_scan: assert property (p_nores_scan) else $error("scan overwrote result");
endmodule
`default_nettype wire

[hw/rtl/arp_resolver_cache.sv]
`default_nettype none
// Channel | Direction | Handshake             | Payload
// s_      | in        | s_valid / s_ready     | one item (send, frame, tick)
// m_      | out       | m_valid / m_ready     | one result, m_last on final
// cfg_    | in        | cfg_we                | cfg_index, cfg_data
// One transaction at a time; s_ready is high only while the controller is idle.
// Send/receive: table walk, decide, then emit.
// Accepted ARP adds learn, a queue walk and a pending clear.
// Tick: table walk, table aging walk, then pending walk.
// Each scan result is emitted before the walk goes on; m_ready low halts the walk in place.
// aresetn clears valid bits, queue count and control state; no clearing pass.
module arp_resolver_cache
    import arp_pkg::*;
#(
    parameter int TABLE_ENTRIES   = TABLE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = PENDING_ENTRIES_DEF,
    parameter int QUEUE_ENTRIES   = QUEUE_ENTRIES_DEF
)(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [31:0] s_next_hop_ip,
    input  wire logic [15:0] s_datagram_id,
    input  wire logic [47:0] s_frame_dst_mac,
    input  wire logic [15:0] s_ether_type,
    input  wire logic        s_payload_ok,
    input  wire logic [15:0] s_arp_opcode,
    input  wire logic [31:0] s_sender_ip,
    input  wire logic [47:0] s_sender_mac,
    input  wire logic [31:0] s_target_ip,
    input  wire logic [47:0] s_target_mac,
    input  wire logic [15:0] s_elapsed_ms,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_out_kind,
    output logic [47:0]      m_dst_mac,
    output logic [31:0]      m_out_target_ip,
    output logic [15:0]      m_out_datagram_id,
    output logic             m_last
);
    cmd_t   cmd;
    sts_t   sts;
    state_t state;
    logic   busy, in_fire, out_fire;

    assign s_ready  = !busy;
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = (state == ST_EMIT) && sts.res_valid;
    assign out_fire = m_valid && m_ready;

    arp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_fire(out_fire),
        .sts(sts), .cmd(cmd), .state(state), .busy(busy)
    );

    arp_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES), .PENDING_ENTRIES(PENDING_ENTRIES),
        .QUEUE_ENTRIES(QUEUE_ENTRIES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .in_kind(s_kind), .in_next_hop_ip(s_next_hop_ip),
        .in_datagram_id(s_datagram_id), .in_frame_dst_mac(s_frame_dst_mac),
        .in_ether_type(s_ether_type), .in_payload_ok(s_payload_ok),
        .in_arp_opcode(s_arp_opcode), .in_sender_ip(s_sender_ip),
        .in_sender_mac(s_sender_mac), .in_target_ip(s_target_ip),
        .in_target_mac(s_target_mac), .in_elapsed_ms(s_elapsed_ms),
        .tick_more(1'b0),
        .res_kind(m_out_kind), .res_mac(m_dst_mac), .res_ip(m_out_target_ip),
        .res_id(m_out_datagram_id), .res_last(m_last)
    );
endmodule
`default_nettype wire

[tb/sv/tb_arp_resolver_cache.sv]
`timescale 1ns / 100ps

module tb_arp_resolver_cache;
    import arp_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] nh_addr;
        logic [15:0] dgram;
        logic [47:0] dst;
        logic [15:0] etype;
        logic        ok;
        logic [15:0] opcode;
        logic [31:0] sip;
        logic [47:0] smac;
        logic [31:0] tip;
        logic [47:0] tmac;
        logic [15:0] elapsed;
    } arp_item_t;

    typedef struct {
        logic [2:0]  kind;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [15:0] dgram;
        logic        last;
    } arp_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic [1:0]  s_kind = '0;
    logic [31:0] s_next_hop_ip = '0;
    logic [15:0] s_datagram_id = '0;
    logic [47:0] s_frame_dst_mac = '0;
    logic [15:0] s_ether_type = '0;
    logic        s_payload_ok = 1'b0;
    logic [15:0] s_arp_opcode = '0;
    logic [31:0] s_sender_ip = '0;
    logic [47:0] s_sender_mac = '0;
    logic [31:0] s_target_ip = '0;
    logic [47:0] s_target_mac = '0;
    logic [15:0] s_elapsed_ms = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [2:0]  m_out_kind;
    wire  [47:0] m_dst_mac;
    wire  [31:0] m_out_target_ip;
    wire  [15:0] m_out_datagram_id;
    wire         m_last;

    arp_resolver_cache i_dut (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_kind, .s_next_hop_ip, .s_datagram_id,
        .s_frame_dst_mac, .s_ether_type, .s_payload_ok, .s_arp_opcode,
        .s_sender_ip, .s_sender_mac, .s_target_ip, .s_target_mac, .s_elapsed_ms,
        .m_valid, .m_ready, .m_out_kind, .m_dst_mac, .m_out_target_ip,
        .m_out_datagram_id, .m_last
    );

    always #6 aclk = ~aclk;

    // shadow of the block's configuration and tables
    logic [47:0] my_mac;
    logic [31:0] my_ip;
    logic [15:0] lifetime_ms;
    logic [15:0] retry_ms;
    logic        cache_vld [16];
    logic [31:0] cache_ip  [16];
    logic [47:0] cache_mac [16];
    logic [15:0] cache_ttl [16];
    logic        arp_wait_vld [8];
    logic [31:0] arp_wait_ip  [8];
    logic [15:0] arp_wait_ttl [8];
    logic [31:0] held_ip [16];
    logic [15:0] held_id [16];
    int          held_cnt;

    arp_item_t   item_q [$];
    arp_res_t    step_res [$];
    arp_res_t    expected_res [$];
    logic [31:0] ip_pool [24];
    int          errors = 0;
    int          n_items = 0;
    int          n_results = 0;
    bit          calm = 1'b0;

    function automatic logic [47:0] rnd48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic void add_item(arp_item_t it);
        item_q = {item_q, it};
    endfunction

    function automatic void emit_res(logic [2:0] k, logic [47:0] mac, logic [31:0] ip,
                                     logic [15:0] id);
        arp_res_t r;
        r = '{k, mac, ip, id, 1'b0};
        step_res = {step_res, r};
    endfunction

    function automatic int cache_find(logic [31:0] ip);
        for (int i = 0; i < 16; i++)
            if (cache_vld[i] && cache_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic int arp_wait_find(logic [31:0] ip);
        for (int i = 0; i < 8; i++)
            if (arp_wait_vld[i] && arp_wait_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic void resolve_send(logic [31:0] ip, logic [15:0] id);
        int t;
        int p;
        t = cache_find(ip);
        if (t >= 0) begin
            emit_res(OUT_IPV4, cache_mac[t], ip, id);
            return;
        end
        if (held_cnt >= 16) begin
            emit_res(OUT_DROP, '0, ip, id);
            return;
        end
        p = arp_wait_find(ip);
        if (p < 0) begin
            for (int i = 0; i < 8; i++)
                if (!arp_wait_vld[i]) begin
                    p = i;
                    break;
                end
            if (p < 0) begin
                emit_res(OUT_DROP, '0, ip, id);
                return;
            end
            arp_wait_vld[p] = 1'b1;
            arp_wait_ip[p] = ip;
            arp_wait_ttl[p] = retry_ms;
            emit_res(OUT_ARP_REQ, MAC_BCAST, ip, '0);
        end
        held_ip[held_cnt] = ip;
        held_id[held_cnt] = id;
        held_cnt++;
    endfunction

    function automatic void learn_mapping(logic [31:0] ip, logic [47:0] mac);
        int slot;
        slot = cache_find(ip);
        if (slot < 0)
            for (int i = 0; i < 16; i++)
                if (!cache_vld[i]) begin
                    slot = i;
                    break;
                end
        if (slot < 0) begin
            // evict the entry closest to expiry, lowest index on ties
            slot = 0;
            for (int i = 1; i < 16; i++)
                if (cache_ttl[i] < cache_ttl[slot]) slot = i;
        end
        cache_vld[slot] = 1'b1;
        cache_ip[slot] = ip;
        cache_mac[slot] = mac;
        cache_ttl[slot] = lifetime_ms;
    endfunction

    function automatic void resolve_frame(arp_item_t it);
        bit is_req;
        bit is_rep;
        int w;
        int p;
        if (it.dst != my_mac && it.dst != MAC_BCAST) return;
        if (!it.ok) return;
        if (it.etype == ETH_IPV4) begin
            emit_res(OUT_DELIVER, '0, '0, it.dgram);
            return;
        end
        if (it.etype != ETH_ARP) return;
        is_req = it.opcode == ARP_OP_REQ && it.tip == my_ip;
        is_rep = it.opcode == ARP_OP_REP && it.tmac == my_mac;
        if (is_req) emit_res(OUT_ARP_REP, it.smac, it.sip, '0);
        if (!(is_req || is_rep)) return;
        learn_mapping(it.sip, it.smac);
        w = 0;
        for (int i = 0; i < held_cnt; i++) begin
            if (held_ip[i] == it.sip) begin
                emit_res(OUT_IPV4, it.smac, it.sip, held_id[i]);
            end else begin
                held_ip[w] = held_ip[i];
                held_id[w] = held_id[i];
                w++;
            end
        end
        held_cnt = w;
        p = arp_wait_find(it.sip);
        if (p >= 0) arp_wait_vld[p] = 1'b0;
    endfunction

    function automatic void age_entries(logic [15:0] el);
        for (int i = 0; i < 16; i++) begin
            if (!cache_vld[i]) continue;
            if (cache_ttl[i] <= el) cache_vld[i] = 1'b0;
            else cache_ttl[i] = cache_ttl[i] - el;
        end
        for (int i = 0; i < 8; i++) begin
            if (!arp_wait_vld[i]) continue;
            if (arp_wait_ttl[i] <= el) begin
                emit_res(OUT_ARP_REQ, MAC_BCAST, arp_wait_ip[i], '0);
                arp_wait_ttl[i] = retry_ms;
            end else begin
                arp_wait_ttl[i] = arp_wait_ttl[i] - el;
            end
        end
    endfunction

    function automatic void predict_results(arp_item_t it);
        step_res.delete();
        case (it.kind)
            KIND_SEND: resolve_send(it.nh_addr, it.dgram);
            KIND_RECV: resolve_frame(it);
            KIND_TICK: age_entries(it.elapsed);
            default: ;
        endcase
        if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[i]) expected_res = {expected_res, step_res[i]};
    endfunction

    // driver
    arp_item_t cur;
    int        s_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_results(cur);
                n_items++;
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    cur = item_q.pop_front();
                    s_kind <= cur.kind;
                    s_next_hop_ip <= cur.nh_addr;
                    s_datagram_id <= cur.dgram;
                    s_frame_dst_mac <= cur.dst;
                    s_ether_type <= cur.etype;
                    s_payload_ok <= cur.ok;
                    s_arp_opcode <= cur.opcode;
                    s_sender_ip <= cur.sip;
                    s_sender_mac <= cur.smac;
                    s_target_ip <= cur.tip;
                    s_target_mac <= cur.tmac;
                    s_elapsed_ms <= cur.elapsed;
                    s_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 4) == 0) s_gap = $urandom_range(1, 14);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side backpressure
    int m_gap = 0;
    always @(posedge aclk) begin
        arp_res_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_res.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d ip=%h id=%h", $time,
                             m_out_kind, m_out_target_ip, m_out_datagram_id);
                    errors++;
                end else begin
                    e = expected_res.pop_front();
                    if (m_out_kind !== e.kind) begin
                        $display("%0t: out_kind exp %0d act %0d", $time, e.kind, m_out_kind);
                        errors++;
                    end
                    if (m_dst_mac !== e.mac) begin
                        $display("%0t: dst_mac exp %h act %h", $time, e.mac, m_dst_mac);
                        errors++;
                    end
                    if (m_out_target_ip !== e.ip) begin
                        $display("%0t: out_target_ip exp %h act %h", $time, e.ip,
                                 m_out_target_ip);
                        errors++;
                    end
                    if (m_out_datagram_id !== e.dgram) begin
                        $display("%0t: out_datagram_id exp %h act %h", $time, e.dgram,
                                 m_out_datagram_id);
                        errors++;
                    end
                    if (m_last !== e.last) begin
                        $display("%0t: last exp %b act %b", $time, e.last, m_last);
                        errors++;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 6) == 0) m_gap = $urandom_range(1, 14);
            end
        end
    end

    function automatic arp_item_t blank_item(logic [1:0] k);
        arp_item_t it;
        it = '{k, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0};
        return it;
    endfunction

    function automatic arp_item_t send_item(logic [31:0] ip, logic [15:0] id);
        arp_item_t it;
        it = blank_item(KIND_SEND);
        it.nh_addr = ip;
        it.dgram = id;
        return it;
    endfunction

    function automatic arp_item_t arp_item(logic [47:0] dst, logic [15:0] op, logic [31:0] sip,
                                           logic [47:0] smac, logic [31:0] tip,
                                           logic [47:0] tmac);
        arp_item_t it;
        it = blank_item(KIND_RECV);
        it.dst = dst;
        it.etype = ETH_ARP;
        it.ok = 1'b1;
        it.opcode = op;
        it.sip = sip;
        it.smac = smac;
        it.tip = tip;
        it.tmac = tmac;
        return it;
    endfunction

    function automatic arp_item_t ipv4_item(logic [47:0] dst, logic [15:0] id, logic ok);
        arp_item_t it;
        it = blank_item(KIND_RECV);
        it.dst = dst;
        it.etype = ETH_IPV4;
        it.ok = ok;
        it.dgram = id;
        return it;
    endfunction

    function automatic arp_item_t tick_item(logic [15:0] el);
        arp_item_t it;
        it = blank_item(KIND_TICK);
        it.elapsed = el;
        return it;
    endfunction

    function automatic arp_item_t noise_item();
        arp_item_t it;
        it = '{2'($urandom_range(0, 3)), $urandom, 16'($urandom), rnd48(), 16'($urandom),
               1'($urandom), 16'($urandom), $urandom, rnd48(), $urandom, rnd48(),
               16'($urandom)};
        return it;
    endfunction

    function automatic logic [47:0] my_dst();
        return $urandom_range(0, 1) ? my_mac : MAC_BCAST;
    endfunction

    function automatic logic [31:0] pool_ip();
        return ip_pool[$urandom_range(0, 2) != 0 ? $urandom_range(0, 11) : $urandom_range(0, 23)];
    endfunction

    function automatic arp_item_t random_item();
        arp_item_t it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            it = send_item(pool_ip(), 16'($urandom));
        end else if (r < 55) begin
            it = arp_item(my_dst(), ARP_OP_REP, pool_ip(), rnd48(), $urandom, my_mac);
        end else if (r < 64) begin
            it = arp_item(my_dst(), ARP_OP_REQ, pool_ip(), rnd48(), my_ip, rnd48());
        end else if (r < 71) begin
            it = ipv4_item(my_dst(), 16'($urandom), 1'b1);
        end else if (r < 85) begin
            case ($urandom_range(0, 3))
                0: it = tick_item(16'($urandom));
                1: it = tick_item(retry_ms);
                default: it = tick_item(16'($urandom_range(0, 3000)));
            endcase
        end else if (r < 92) begin
            it = noise_item();
        end else begin
            // near misses of a well-formed ARP transaction
            it = arp_item(my_dst(), ARP_OP_REP, pool_ip(), rnd48(), $urandom, my_mac);
            case ($urandom_range(0, 3))
                0: it.dst = rnd48();
                1: it.ok = 1'b0;
                2: it.opcode = 16'($urandom_range(3, 65535));
                default: it.tmac = ~my_mac;
            endcase
        end
        return it;
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [47:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_OWN_MAC:  my_mac = val;
            CFG_OWN_IP:   my_ip = val[31:0];
            CFG_LIFETIME: lifetime_ms = val[15:0];
            CFG_RETRY:    retry_ms = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(logic [47:0] mac, logic [31:0] ip, logic [15:0] life,
                         logic [15:0] retry);
        cfg_write(CFG_OWN_MAC, mac);
        cfg_write(CFG_OWN_IP, {16'h0, ip});
        cfg_write(CFG_LIFETIME, {32'h0, life});
        cfg_write(CFG_RETRY, {32'h0, retry});
    endtask

    task automatic drain();
        @(posedge aclk);
        #1;
        while (item_q.size() > 0 || s_valid || expected_res.size() > 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (80) @(posedge aclk);
    endtask

    initial begin
        arp_item_t it;
        logic [31:0] ip_a;
        logic [31:0] ip_c;
        my_mac = '0;
        my_ip = '0;
        lifetime_ms = 16'd30000;
        retry_ms = 16'd5000;
        foreach (cache_vld[i]) cache_vld[i] = 1'b0;
        foreach (arp_wait_vld[i]) arp_wait_vld[i] = 1'b0;
        held_cnt = 0;
        foreach (ip_pool[i]) ip_pool[i] = $urandom;
        ip_a = ip_pool[0];
        ip_c = ip_pool[2];

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        setup(48'h02_00_00_00_00_01, 32'h0A00_0001, 16'd30000, 16'd5000);
        add_item(send_item(ip_a, 16'h0000));
        add_item(send_item(ip_a, 16'hFFFF));
        add_item(arp_item(my_mac, ARP_OP_REP, ip_a, 48'hFFFF_FFFF_FFFE, '0, my_mac));
        add_item(send_item(ip_a, 16'h1234));
        add_item(arp_item(MAC_BCAST, ARP_OP_REQ, ip_pool[1], 48'h0, my_ip, '0));
        add_item(ipv4_item(my_mac, 16'hFFFF, 1'b1));
        add_item(ipv4_item(my_mac, 16'h0001, 1'b0));
        add_item(ipv4_item(48'h0, 16'h0002, 1'b1));
        it = ipv4_item(my_mac, 16'h0003, 1'b1);
        it.etype = 16'hFFFF;
        add_item(it);
        add_item(arp_item(my_mac, 16'd3, ip_a, '1, my_ip, my_mac));
        add_item(arp_item(my_mac, ARP_OP_REQ, ip_a, '1, ~my_ip, my_mac));
        add_item(arp_item(my_mac, ARP_OP_REP, ip_a, '1, my_ip, ~my_mac));
        it = noise_item();
        it.kind = KIND_NONE;
        add_item(it);
        add_item(send_item(ip_c, 16'h0C00));
        add_item(tick_item(16'd0));
        add_item(tick_item(16'd5000));
        add_item(tick_item(16'hFFFF));
        // fill the pending set, then one more target is dropped
        for (int i = 0; i < 8; i++) add_item(send_item(32'hC0A8_0000 + 32'(i), 16'(i)));
        // fill the datagram queue, then one more is dropped
        for (int i = 0; i < 9; i++) add_item(send_item(ip_c, 16'(16'h0C01 + i)));
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: ;
                1: setup('1, '1, 16'd1, 16'd1);
                2: setup('0, '0, 16'hFFFF, 16'hFFFF);
                3: setup(rnd48(), $urandom, 16'd0, 16'd0);
                default: begin
                    setup(rnd48(), $urandom, 16'($urandom_range(2000, 40000)),
                          16'($urandom_range(500, 8000)));
                    calm = 1'b1;
                end
            endcase
            for (int i = 0; i < 50; i++) add_item(random_item());
            drain();
        end

        if (expected_res.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_res.size());
            errors++;
        end
        $display("Ran %0d items through 5 configuration settings, %0d results checked, %0d errors.",
                 n_items, n_results, errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout at %0t", $time);
        $display("Simulation FAILED");
        $finish;
    end
endmodule
